[rtl/mrf_pkg.sv]
// Shared types and constants for the message ring FIFO.
package mrf_pkg;

   // Fixed field widths of the request and response words.
   localparam int LEN_W    = 8;
   localparam int BYTE_W   = 8;
   localparam int ACT_W    = 2;
   localparam int STATUS_W = 3;

   // Request kinds carried in req_tuser. The fourth code is ignored.
   localparam logic [ACT_W-1:0] ACT_OPEN = 2'd0;
   localparam logic [ACT_W-1:0] ACT_PUSH = 2'd1;
   localparam logic [ACT_W-1:0] ACT_POP  = 2'd2;

   // Response status codes.
   localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
   localparam logic [STATUS_W-1:0] ST_BUSY     = 3'd1;
   localparam logic [STATUS_W-1:0] ST_TOO_LONG = 3'd2;
   localparam logic [STATUS_W-1:0] ST_NO_SPACE = 3'd3;
   localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd4;
   localparam logic [STATUS_W-1:0] ST_NO_OPEN  = 3'd5;

   typedef enum logic [1:0] {
      S_IDLE,
      S_EXEC,
      S_DESC,
      S_BYTE
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic capture;
      logic desc_rd;
      logic byte_rd_cur;
      logic byte_rd_desc;
      logic commit;
   } dp_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic pop_start;
      logic pop_cont;
      logic desc_len_zero;
      logic out_free;
   } dp_status_type;

endpackage

[rtl/mrf_ctrl.sv]
// Controller state machine for the message ring FIFO.
module mrf_ctrl
   import mrf_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  dp_status_type dp_status,
   output dp_cmd_type    dp_cmd
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      dp_cmd     = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               dp_cmd.capture = 1'b1;
               state_in       = S_EXEC;
            end
         end
         S_EXEC: begin
            // A pop that opens a new message first fetches its descriptor.
            if (dp_status.pop_start) begin
               dp_cmd.desc_rd = 1'b1;
               state_in       = S_DESC;
            end else if (dp_status.pop_cont) begin
               dp_cmd.byte_rd_cur = 1'b1;
               state_in           = S_BYTE;
            end else if (dp_status.out_free) begin
               dp_cmd.commit = 1'b1;
               state_in      = S_IDLE;
            end
         end
         S_DESC: begin
            if (!dp_status.desc_len_zero) begin
               dp_cmd.byte_rd_desc = 1'b1;
               state_in            = S_BYTE;
            end else if (dp_status.out_free) begin
               dp_cmd.commit = 1'b1;
               state_in      = S_IDLE;
            end
         end
         S_BYTE: begin
            if (dp_status.out_free) begin
               dp_cmd.commit = 1'b1;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

[rtl/mrf_datapath.sv]
// Datapath of the message ring FIFO: rings, pointers, counters and response register.
module mrf_datapath
   import mrf_pkg::*;
#(
   parameter int DATA_DEPTH = 256,
   parameter int DESC_DEPTH = 16
)
(
   input  logic                clock,
   input  logic                reset,
   input  dp_cmd_type          dp_cmd,
   output dp_status_type       dp_status,
   input  logic [ACT_W-1:0]    act,
   input  logic [BYTE_W-1:0]   data_in,
   input  logic [LEN_W-1:0]    msg_length_in,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [STATUS_W-1:0] rsp_status,
   output logic [BYTE_W-1:0]   rsp_data_out,
   output logic                rsp_data_valid,
   output logic                rsp_last,
   output logic [LEN_W-1:0]    rsp_msg_length,
   output logic                rsp_queue_empty
);

   localparam int AW   = $clog2(DATA_DEPTH);
   localparam int BCW  = $clog2(DATA_DEPTH + 1);
   localparam int PW   = $clog2(DESC_DEPTH);
   localparam int DCW  = $clog2(DESC_DEPTH + 1);
   localparam int XW   = LEN_W + 1;

   logic [BYTE_W-1:0] byte_mem  [DATA_DEPTH];
   logic [AW-1:0]     dstart_mem[DESC_DEPTH];
   logic [LEN_W-1:0]  dlen_mem  [DESC_DEPTH];

   // Captured request word.
   logic [ACT_W-1:0]  act_ff;
   logic [BYTE_W-1:0] din_ff;
   logic [LEN_W-1:0]  len_ff;

   // Registered memory read data.
   logic [BYTE_W-1:0] byte_q_ff;
   logic [AW-1:0]     dstart_q_ff;
   logic [LEN_W-1:0]  dlen_q_ff;

   // Queue state.
   logic [PW-1:0]    desc_wr_ptr_ff, desc_wr_ptr_in;
   logic [PW-1:0]    desc_rd_ptr_ff, desc_rd_ptr_in;
   logic [DCW-1:0]   desc_count_ff, desc_count_in;
   logic [AW-1:0]    byte_wr_ptr_ff, byte_wr_ptr_in;
   logic [BCW-1:0]   bytes_stored_ff, bytes_stored_in;
   logic [LEN_W-1:0] push_left_ff, push_left_in;
   logic [AW-1:0]    pop_addr_ff, pop_addr_in;
   logic [LEN_W-1:0] pop_left_ff, pop_left_in;
   logic [LEN_W-1:0] pop_len_ff, pop_len_in;

   // Response register.
   logic                rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] status_ff, status_in;
   logic [BYTE_W-1:0]   dout_ff, dout_in;
   logic                dvalid_ff, dvalid_in;
   logic                last_ff, last_in;
   logic                empty_ff;

   logic [AW-1:0]    eff_addr;
   logic [LEN_W-1:0] eff_left;
   logic [XW-1:0]    free_bytes;
   logic             open_ok;
   logic             push_ok;
   logic             out_free;

   assign out_free = !rsp_valid_ff || rsp_ready;

   assign dp_status.pop_start     = (act_ff == ACT_POP) && (pop_left_ff == '0)
                                    && (push_left_ff == '0) && (desc_count_ff != '0);
   assign dp_status.pop_cont      = (act_ff == ACT_POP) && (pop_left_ff != '0);
   assign dp_status.desc_len_zero = (dlen_q_ff == '0);
   assign dp_status.out_free      = out_free;

   assign free_bytes = XW'(DATA_DEPTH) - XW'(bytes_stored_ff);

   always_comb begin
      desc_wr_ptr_in  = desc_wr_ptr_ff;
      desc_rd_ptr_in  = desc_rd_ptr_ff;
      desc_count_in   = desc_count_ff;
      byte_wr_ptr_in  = byte_wr_ptr_ff;
      bytes_stored_in = bytes_stored_ff;
      push_left_in    = push_left_ff;
      pop_addr_in     = pop_addr_ff;
      pop_left_in     = pop_left_ff;
      pop_len_in      = pop_len_ff;
      status_in       = ST_OK;
      dout_in         = '0;
      dvalid_in       = 1'b0;
      last_in         = 1'b0;
      eff_addr        = pop_addr_ff;
      eff_left        = pop_left_ff;
      open_ok         = 1'b0;
      push_ok         = 1'b0;
      unique case (act_ff)
         ACT_OPEN: begin
            priority if (push_left_ff != '0 || pop_left_ff != '0) begin
               status_in = ST_BUSY;
            end else if ({1'b0, len_ff} > XW'(DATA_DEPTH)) begin
               status_in = ST_TOO_LONG;
            end else if ({1'b0, len_ff} > free_bytes
                         || desc_count_ff >= DCW'(DESC_DEPTH)) begin
               status_in = ST_NO_SPACE;
            end else begin
               open_ok         = 1'b1;
               desc_wr_ptr_in  = (desc_wr_ptr_ff == PW'(DESC_DEPTH - 1)) ? '0
                                 : desc_wr_ptr_ff + 1'b1;
               desc_count_in   = desc_count_ff + 1'b1;
               bytes_stored_in = bytes_stored_ff + BCW'(len_ff);
               push_left_in    = len_ff;
               last_in         = (len_ff == '0);
            end
         end
         ACT_PUSH: begin
            if (push_left_ff == '0) begin
               status_in = ST_NO_OPEN;
            end else begin
               push_ok        = 1'b1;
               byte_wr_ptr_in = (byte_wr_ptr_ff == AW'(DATA_DEPTH - 1)) ? '0
                                : byte_wr_ptr_ff + 1'b1;
               push_left_in   = push_left_ff - 1'b1;
               last_in        = (push_left_ff == LEN_W'(1));
            end
         end
         ACT_POP: begin
            if (pop_left_ff == '0) begin
               priority if (push_left_ff != '0) begin
                  status_in = ST_BUSY;
               end else if (desc_count_ff == '0) begin
                  status_in = ST_EMPTY;
               end else begin
                  // Take the descriptor that was fetched for this word.
                  eff_addr       = dstart_q_ff;
                  eff_left       = dlen_q_ff;
                  pop_addr_in    = dstart_q_ff;
                  pop_len_in     = dlen_q_ff;
                  pop_left_in    = dlen_q_ff;
                  desc_rd_ptr_in = (desc_rd_ptr_ff == PW'(DESC_DEPTH - 1)) ? '0
                                   : desc_rd_ptr_ff + 1'b1;
                  desc_count_in  = desc_count_ff - 1'b1;
                  last_in        = (dlen_q_ff == '0);
               end
            end
            if (status_in == ST_OK && eff_left != '0) begin
               dout_in     = byte_q_ff;
               dvalid_in   = 1'b1;
               pop_addr_in = (eff_addr == AW'(DATA_DEPTH - 1)) ? '0 : eff_addr + 1'b1;
               pop_left_in = eff_left - 1'b1;
               if (bytes_stored_ff != '0) begin
                  bytes_stored_in = bytes_stored_ff - 1'b1;
               end
               last_in     = (eff_left == LEN_W'(1));
            end
         end
         default: begin
            status_in = ST_OK;
         end
      endcase
   end

   always_comb begin
      if (dp_cmd.commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         desc_wr_ptr_ff  <= '0;
         desc_rd_ptr_ff  <= '0;
         desc_count_ff   <= '0;
         byte_wr_ptr_ff  <= '0;
         bytes_stored_ff <= '0;
         push_left_ff    <= '0;
         pop_addr_ff     <= '0;
         pop_left_ff     <= '0;
         pop_len_ff      <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (dp_cmd.commit) begin
            desc_wr_ptr_ff  <= desc_wr_ptr_in;
            desc_rd_ptr_ff  <= desc_rd_ptr_in;
            desc_count_ff   <= desc_count_in;
            byte_wr_ptr_ff  <= byte_wr_ptr_in;
            bytes_stored_ff <= bytes_stored_in;
            push_left_ff    <= push_left_in;
            pop_addr_ff     <= pop_addr_in;
            pop_left_ff     <= pop_left_in;
            pop_len_ff      <= pop_len_in;
         end
      end
   end

   // Payload registers: request capture and response word.
   always_ff @(posedge clock) begin
      if (dp_cmd.capture) begin
         act_ff <= act;
         din_ff <= data_in;
         len_ff <= msg_length_in;
      end
      if (dp_cmd.commit) begin
         status_ff <= status_in;
         dout_ff   <= dout_in;
         dvalid_ff <= dvalid_in;
         last_ff   <= last_in;
         empty_ff  <= (desc_count_in == '0) && (pop_left_in == '0);
      end
   end

   // Byte ring: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (dp_cmd.commit && push_ok) begin
         byte_mem[byte_wr_ptr_ff] <= din_ff;
      end
      if (dp_cmd.byte_rd_cur) begin
         byte_q_ff <= byte_mem[pop_addr_ff];
      end else if (dp_cmd.byte_rd_desc) begin
         byte_q_ff <= byte_mem[dstart_q_ff];
      end
   end

   // Descriptor ring.
   always_ff @(posedge clock) begin
      if (dp_cmd.commit && open_ok) begin
         dstart_mem[desc_wr_ptr_ff] <= byte_wr_ptr_ff;
         dlen_mem[desc_wr_ptr_ff]   <= len_ff;
      end
      if (dp_cmd.desc_rd) begin
         dstart_q_ff <= dstart_mem[desc_rd_ptr_ff];
         dlen_q_ff   <= dlen_mem[desc_rd_ptr_ff];
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = status_ff;
   assign rsp_data_out    = dout_ff;
   assign rsp_data_valid  = dvalid_ff;
   assign rsp_last        = last_ff;
   assign rsp_msg_length  = pop_len_ff;
   assign rsp_queue_empty = empty_ff;

   a_bytes_bound: assert property (@(posedge clock) disable iff (reset)
      bytes_stored_ff <= BCW'(DATA_DEPTH))
      else $error("stored byte count above ring size");

   a_desc_bound: assert property (@(posedge clock) disable iff (reset)
      desc_count_ff <= DCW'(DESC_DEPTH))
      else $error("descriptor count above ring size");

   a_push_pop_excl: assert property (@(posedge clock) disable iff (reset)
      !(push_left_ff != '0 && pop_left_ff != '0))
      else $error("push and pop messages open at once");

   a_push_reserved: assert property (@(posedge clock) disable iff (reset)
      BCW'(push_left_ff) <= bytes_stored_ff)
      else $error("bytes still due for push are not reserved");

   a_commit_free: assert property (@(posedge clock) disable iff (reset)
      dp_cmd.commit |-> out_free)
      else $error("response overwritten before it was taken");

endmodule

[rtl/message_ring_fifo_core.sv]
// Top level of the message ring FIFO: variable-length byte messages in a ring.
//
//  channel | direction | tdata                                  | tuser / tlast
//  --------+-----------+----------------------------------------+-----------------------------
//  req     | in        | [7:0] data_in, [15:8] msg_length_in    | tuser[1:0] action
//  rsp     | out       | [7:0] data_out, [15:8] msg_length_out, | tuser[2:0] status,
//          |           | [16] queue_empty, [23:17] zero         | tuser[3] data_valid, tlast
//
// One word is worked at a time: an open, a push, a refused or an ignored word runs
// through S_IDLE and S_EXEC, a pop within a message adds S_BYTE (one byte-ring read),
// the first pop of a message adds S_DESC, then S_BYTE (S_BYTE skipped if empty). The response
// loads in the last of those states; while it waits for rsp_tready the next word stalls.
// Reset is synchronous and clears the controller, pointers, counters and response valid;
// the rings are not swept, as no entry is read before it has been written.
module message_ring_fifo_core
   import mrf_pkg::*;
#(
   parameter int DATA_DEPTH = 256,
   parameter int DESC_DEPTH = 16
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [7:0] data_in, [15:8] msg_length_in
   input  logic [1:0]  req_tuser,   // [1:0] action
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [7:0] data_out, [15:8] msg_length_out, [16] queue_empty
   output logic [3:0]  rsp_tuser,   // [2:0] status, [3] data_valid
   output logic        rsp_tlast    // end of a message: last byte, or a zero-length open or pop
);

   dp_cmd_type          dp_cmd;
   dp_status_type       dp_status;
   logic [STATUS_W-1:0] rsp_status;
   logic [BYTE_W-1:0]   rsp_data_out;
   logic                rsp_data_valid;
   logic [LEN_W-1:0]    rsp_msg_length;
   logic                rsp_queue_empty;

   // The controller sequences each word through capture, optional descriptor
   // and byte reads, and a single commit into the response register.
   mrf_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .dp_status  (dp_status),
      .dp_cmd     (dp_cmd)
   );

   // The datapath holds both rings, all queue state and the response word.
   mrf_datapath #(
      .DATA_DEPTH (DATA_DEPTH),
      .DESC_DEPTH (DESC_DEPTH)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .dp_cmd          (dp_cmd),
      .dp_status       (dp_status),
      .act             (req_tuser[ACT_W-1:0]),
      .data_in         (req_tdata[7:0]),
      .msg_length_in   (req_tdata[15:8]),
      .rsp_valid       (rsp_tvalid),
      .rsp_ready       (rsp_tready),
      .rsp_status      (rsp_status),
      .rsp_data_out    (rsp_data_out),
      .rsp_data_valid  (rsp_data_valid),
      .rsp_last        (rsp_tlast),
      .rsp_msg_length  (rsp_msg_length),
      .rsp_queue_empty (rsp_queue_empty)
   );

   // Pack the response fields, lowest field first, zero fill to whole bytes.
   assign rsp_tdata = {7'd0, rsp_queue_empty, rsp_msg_length, rsp_data_out};
   assign rsp_tuser = {rsp_data_valid, rsp_status};

endmodule
